### hw/rtl/uwn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwn_pkg
// Shared types and constants for the white-space normalizer: code point
// widths, configuration register indexes and the character codes that the
// classifier recognizes.
// ----------------------------------------------------------------------------
package uwn_pkg;

  // code point and configuration port widths
  localparam int CP_W       = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // default depth of the trailing white-space store
  localparam int TRAIL_DEPTH_DEF = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE_SPACES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLLAPSE_NEWLINES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_LEADING      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_TRAILING     = 2'd3;

  // character codes
  localparam logic [CP_W-1:0] CP_TAB      = 21'h00_0009;
  localparam logic [CP_W-1:0] CP_LF       = 21'h00_000A;
  localparam logic [CP_W-1:0] CP_VT       = 21'h00_000B;
  localparam logic [CP_W-1:0] CP_FF       = 21'h00_000C;
  localparam logic [CP_W-1:0] CP_CR       = 21'h00_000D;
  localparam logic [CP_W-1:0] CP_SPACE    = 21'h00_0020;
  localparam logic [CP_W-1:0] CP_NEL      = 21'h00_0085;
  localparam logic [CP_W-1:0] CP_NBSP     = 21'h00_00A0;
  localparam logic [CP_W-1:0] CP_OGHAM    = 21'h00_1680;
  localparam logic [CP_W-1:0] CP_EN_QUAD  = 21'h00_2000;
  localparam logic [CP_W-1:0] CP_HAIR_SP  = 21'h00_200A;
  localparam logic [CP_W-1:0] CP_LINE_SEP = 21'h00_2028;
  localparam logic [CP_W-1:0] CP_PARA_SEP = 21'h00_2029;
  localparam logic [CP_W-1:0] CP_NNBSP    = 21'h00_202F;
  localparam logic [CP_W-1:0] CP_MMSP     = 21'h00_205F;
  localparam logic [CP_W-1:0] CP_IDEO_SP  = 21'h00_3000;

  // mode bits that steer the classifier
  typedef struct packed {
    logic collapse_spaces;
    logic collapse_newlines;
  } cls_mode_t;

  // classifier verdict for one code point
  typedef struct packed {
    logic white;
    logic collapsible;
  } cls_t;

endpackage : uwn_pkg
`default_nettype wire

### hw/rtl/unicode_whitespace_normalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_whitespace_normalizer_unit
// Collapses runs of white space into one space and trims leading and
// trailing white space, one code point per input word.
// ----------------------------------------------------------------------------
// An input word is taken when the unit is idle. A word that produces no
// result, or one that is only held as trailing white space, is done in the
// cycle it is taken; a word that emits its own character goes out from
// S_PUTP. When a non-space arrives behind held trailing white space, the
// store drains first in S_SEND at one word per cycle from its single read
// port, while the output does not stall, and then the word itself goes out
// from S_PUTP. A store overflow, which emits the oldest held entry, goes out
// from S_SEND. Results leave through an output register, so a finished word
// may wait for the consumer while the store pointer logic has already moved
// on. The store holds TRAIL_DEPTH entries in a circular buffer with a head
// pointer and a fill count; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module unicode_whitespace_normalizer_unit #(
  parameter int TRAIL_DEPTH = uwn_pkg::TRAIL_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [uwn_pkg::CP_W-1:0]        in_code_point,
  input  wire logic                            in_final_char,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [uwn_pkg::CP_W-1:0]        out_char,
  output logic                                 out_has_char,
  output logic                                 out_end_of_text,
  output logic                                 out_store_overflow,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [uwn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uwn_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int CNT_W = $clog2(TRAIL_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TRAIL_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(TRAIL_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TRAIL_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEND,
    S_PUTP
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic              bfc_r, bfc_nxt;
  logic              run_r, run_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ovf_mode_r, ovf_mode_nxt;

  // configuration registers
  logic              col_sp_r, col_sp_nxt;
  logic              col_nl_r, col_nl_nxt;
  logic              trim_l_r, trim_l_nxt;
  logic              trim_t_r, trim_t_nxt;

  // pending word of the current item
  logic [uwn_pkg::CP_W-1:0] p_r, p_nxt;
  logic                     has_r, has_nxt;
  logic                     fin_r, fin_nxt;

  // output register
  logic                     ovalid_r, ovalid_nxt;
  logic [uwn_pkg::CP_W-1:0] ochar_r, ochar_nxt;
  logic                     ohas_r, ohas_nxt;
  logic                     oeot_r, oeot_nxt;
  logic                     oovf_r, oovf_nxt;

  // store ports
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [uwn_pkg::CP_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [IDX_W-1:0]         mem_raddr;
  logic [uwn_pkg::CP_W-1:0] mem_rdata;

  // decode of the incoming word
  uwn_pkg::cls_mode_t       mode;
  uwn_pkg::cls_t            cls;
  logic                     accept;
  logic                     drop;
  logic                     have;
  logic [uwn_pkg::CP_W-1:0] p_in;
  logic                     p_white;
  logic                     hold;
  logic                     full;
  logic                     can_push;
  logic [SUM_W-1:0]         tail_sum;
  logic [IDX_W-1:0]         tail;
  logic [IDX_W-1:0]         head_inc;

  assign mode.collapse_spaces   = col_sp_r;
  assign mode.collapse_newlines = col_nl_r;

  uwn_classify u_cls (
    .cp   (in_code_point),
    .mode (mode),
    .cls  (cls)
  );

  uwn_trail_mem #(
    .DEPTH  (TRAIL_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // per-word decisions
  assign accept   = in_valid && (state_r == S_IDLE);
  assign drop     = bfc_r && trim_l_r && cls.white;
  assign have     = !drop && (!cls.collapsible || !run_r);
  assign p_in     = cls.collapsible ? uwn_pkg::CP_SPACE : in_code_point;
  assign p_white  = cls.collapsible || cls.white;
  assign hold     = trim_t_r && p_white;
  assign full     = (count_r == CNT_FULL);
  assign can_push = !ovalid_r || out_ready;

  // circular buffer pointers
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail     = (tail_sum >= SUM_WRAP) ? IDX_W'(tail_sum - SUM_WRAP) : IDX_W'(tail_sum);
  assign head_inc = (head_r == IDX_LAST) ? '0 : IDX_W'(head_r + IDX_W'(1));

  // next-state logic
  always_comb begin
    state_nxt    = state_r;
    bfc_nxt      = bfc_r;
    run_nxt      = run_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    ovf_mode_nxt = ovf_mode_r;
    col_sp_nxt   = col_sp_r;
    col_nl_nxt   = col_nl_r;
    trim_l_nxt   = trim_l_r;
    trim_t_nxt   = trim_t_r;
    p_nxt        = p_r;
    has_nxt      = has_r;
    fin_nxt      = fin_r;
    ovalid_nxt   = ovalid_r && !out_ready;
    ochar_nxt    = ochar_r;
    ohas_nxt     = ohas_r;
    oeot_nxt     = oeot_r;
    oovf_nxt     = oovf_r;
    mem_we       = 1'b0;
    mem_waddr    = tail;
    mem_wdata    = p_in;
    mem_re       = 1'b0;
    mem_raddr    = head_r;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        uwn_pkg::REG_COLLAPSE_SPACES:   col_sp_nxt = cfg_data[0];
        uwn_pkg::REG_COLLAPSE_NEWLINES: col_nl_nxt = cfg_data[0];
        uwn_pkg::REG_TRIM_LEADING:      trim_l_nxt = cfg_data[0];
        uwn_pkg::REG_TRIM_TRAILING:     trim_t_nxt = cfg_data[0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (bfc_r && !drop) begin
            bfc_nxt = 1'b0;
          end
          if (!drop) begin
            run_nxt = cls.collapsible;
          end
          p_nxt   = p_in;
          has_nxt = 1'b1;
          fin_nxt = in_final_char;
          if (!have || (hold && !full)) begin
            // nothing to emit now; a final word still needs its end marker
            if (in_final_char) begin
              p_nxt     = '0;
              has_nxt   = 1'b0;
              state_nxt = S_PUTP;
            end else if (have) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CNT_ONE;
            end
          end else if (hold) begin
            // store full: pop the oldest entry, then store the new one
            mem_re       = 1'b1;
            ovf_mode_nxt = 1'b1;
            state_nxt    = S_SEND;
          end else if (count_r != '0) begin
            // drain held white space ahead of this character
            mem_re       = 1'b1;
            ovf_mode_nxt = 1'b0;
            state_nxt    = S_SEND;
          end else begin
            state_nxt = S_PUTP;
          end
        end
      end

      S_SEND: begin
        if (can_push) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = mem_rdata;
          ohas_nxt   = 1'b1;
          oovf_nxt   = ovf_mode_r || ovf_r;
          oeot_nxt   = ovf_mode_r && fin_r;
          head_nxt   = head_inc;
          if (ovf_mode_r) begin
            // new entry takes the slot just freed
            mem_we    = 1'b1;
            mem_waddr = head_r;
            mem_wdata = p_r;
            ovf_nxt   = 1'b1;
            state_nxt = S_IDLE;
            if (fin_r) begin
              bfc_nxt   = 1'b1;
              run_nxt   = 1'b0;
              head_nxt  = '0;
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
          end else begin
            count_nxt = count_r - CNT_ONE;
            if (count_r == CNT_ONE) begin
              state_nxt = S_PUTP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = head_inc;
            end
          end
        end
      end

      S_PUTP: begin
        if (can_push) begin
          ovalid_nxt = 1'b1;
          ochar_nxt  = p_r;
          ohas_nxt   = has_r;
          oovf_nxt   = ovf_r;
          oeot_nxt   = fin_r;
          state_nxt  = S_IDLE;
          if (fin_r) begin
            bfc_nxt   = 1'b1;
            run_nxt   = 1'b0;
            head_nxt  = '0;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      bfc_r      <= 1'b1;
      run_r      <= 1'b0;
      head_r     <= '0;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      ovf_mode_r <= 1'b0;
      col_sp_r   <= 1'b1;
      col_nl_r   <= 1'b1;
      trim_l_r   <= 1'b1;
      trim_t_r   <= 1'b1;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bfc_r      <= bfc_nxt;
      run_r      <= run_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      ovf_mode_r <= ovf_mode_nxt;
      col_sp_r   <= col_sp_nxt;
      col_nl_r   <= col_nl_nxt;
      trim_l_r   <= trim_l_nxt;
      trim_t_r   <= trim_t_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    has_r   <= has_nxt;
    fin_r   <= fin_nxt;
    ochar_r <= ochar_nxt;
    ohas_r  <= ohas_nxt;
    oeot_r  <= oeot_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = ovalid_r;
  assign out_char           = ochar_r;
  assign out_has_char       = ohas_r;
  assign out_end_of_text    = oeot_r;
  assign out_store_overflow = oovf_r;

endmodule : unicode_whitespace_normalizer_unit
`default_nettype wire

### hw/rtl/uwn_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwn_classify
// Decides whether a code point is white space and whether it belongs to a
// collapsible run under the current mode bits.
// ----------------------------------------------------------------------------
module uwn_classify (
  input  wire logic [uwn_pkg::CP_W-1:0] cp,
  input  wire uwn_pkg::cls_mode_t       mode,
  output uwn_pkg::cls_t                 cls
);

  logic space_cat;
  logic newline;
  logic tab_like;

  // Zs, Zl and Zp
  assign space_cat = (cp == uwn_pkg::CP_SPACE)    || (cp == uwn_pkg::CP_NBSP)  ||
                     (cp == uwn_pkg::CP_OGHAM)    ||
                     ((cp >= uwn_pkg::CP_EN_QUAD) && (cp <= uwn_pkg::CP_HAIR_SP)) ||
                     (cp == uwn_pkg::CP_NNBSP)    || (cp == uwn_pkg::CP_MMSP)  ||
                     (cp == uwn_pkg::CP_IDEO_SP)  ||
                     (cp == uwn_pkg::CP_LINE_SEP) || (cp == uwn_pkg::CP_PARA_SEP);

  assign newline  = (cp == uwn_pkg::CP_LF) || (cp == uwn_pkg::CP_CR);
  assign tab_like = (cp == uwn_pkg::CP_TAB) || (cp == uwn_pkg::CP_VT) ||
                    (cp == uwn_pkg::CP_FF)  || (cp == uwn_pkg::CP_NEL);

  // verdict
  assign cls.white       = space_cat || newline || tab_like;
  assign cls.collapsible = ((space_cat || tab_like) && mode.collapse_spaces) ||
                           (newline && mode.collapse_newlines);

endmodule : uwn_classify
`default_nettype wire

### hw/rtl/uwn_trail_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwn_trail_mem
// Trailing white-space store: one write port, one read port and registered
// read data.
// ----------------------------------------------------------------------------
module uwn_trail_mem #(
  parameter int DEPTH = uwn_pkg::TRAIL_DEPTH_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [uwn_pkg::CP_W-1:0]  wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output logic      [uwn_pkg::CP_W-1:0]  rdata
);

  logic [uwn_pkg::CP_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : uwn_trail_mem
`default_nettype wire

### hw/rtl/uwn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uwn_checker
// Port-level checks for the white-space normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module uwn_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [uwn_pkg::CP_W-1:0]        out_char,
  input wire logic                            out_has_char,
  input wire logic                            out_end_of_text,
  input wire logic                            out_store_overflow
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(out_has_char) && $stable(out_end_of_text) && $stable(out_store_overflow))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a bare marker only closes a text
  a_marker_eot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_char |-> out_end_of_text)
    else $error("bare marker without end of text");

  // a bare marker carries no character
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_char |-> out_char == '0)
    else $error("bare marker with nonzero character");

endmodule : uwn_checker

bind unicode_whitespace_normalizer_unit uwn_checker u_uwn_checker (.*);
`default_nettype wire
